### hdl/bfdssm_pkg.sv
`default_nettype none

package bfdssm_pkg;

  // table size and field widths
  localparam int unsigned SESSIONS  = 64;
  localparam int unsigned SessIdxW  = $clog2(SESSIONS);
  localparam int unsigned SessionW  = 6;
  localparam int unsigned IntervalW = 32;

  // default transmit interval while not up, and the reset value of each stored cur_tx
  localparam logic [IntervalW-1:0] SLOW_TX_DEFAULT = 32'd1000000;

  // configuration register indexes
  localparam logic CfgSlowTx = 1'b0;
  localparam logic CfgListen = 1'b1;

  // session states
  typedef enum logic [1:0] {
    ST_ADMIN = 2'd0,
    ST_DOWN  = 2'd1,
    ST_INIT  = 2'd2,
    ST_UP    = 2'd3
  } sess_st_e;

  // event codes
  typedef enum logic [2:0] {
    EV_R_ADMIN = 3'd0,
    EV_R_DOWN  = 3'd1,
    EV_R_INIT  = 3'd2,
    EV_R_UP    = 3'd3,
    EV_L_ADMIN = 3'd4,
    EV_L_UP    = 3'd5,
    EV_TIMEOUT = 3'd6,
    EV_INVALID = 3'd7
  } event_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SESS    = 2'd1,
    STAT_LOCAL   = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  // fault timer commands
  typedef enum logic [1:0] {
    FT_NONE  = 2'd0,
    FT_START = 2'd1,
    FT_STOP  = 2'd2
  } fault_cmd_e;

  // diagnostic codes
  localparam logic [3:0] DIAG_NONE     = 4'd0;
  localparam logic [3:0] DIAG_EXPIRED  = 4'd1;
  localparam logic [3:0] DIAG_NEIGHBOR = 4'd3;
  localparam logic [3:0] DIAG_ADMIN    = 4'd7;

  // one session table entry
  typedef struct packed {
    sess_st_e             state;
    logic [3:0]           diag;
    logic [IntervalW-1:0] cur_tx;
    logic                 poll_flag;
    logic [IntervalW-1:0] poll_tx;
    logic [IntervalW-1:0] poll_rx;
  } entry_t;

  localparam entry_t EntryReset = '{
    state:     ST_ADMIN,
    diag:      DIAG_NONE,
    cur_tx:    SLOW_TX_DEFAULT,
    poll_flag: 1'b0,
    poll_tx:   '0,
    poll_rx:   '0
  };

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch item and read the session entry
    logic exec;     // apply the transition, write back, load results
  } dp_cmd_t;

endpackage

`default_nettype wire

### hdl/bfdssm_ctrl.sv
`default_nettype none

module bfdssm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  output logic                     done_o,
  output bfdssm_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DONE = 3'b100
  } ctrl_st_e;

  ctrl_st_e state_q, state_d;
  logic     accept;

  assign busy   = (state_q == S_LOOK);
  assign done_o = (state_q == S_DONE);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_LOOK : S_IDLE;
      S_LOOK:  state_d = S_DONE;
      S_DONE:  state_d = accept ? S_LOOK : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath commands
  assign cmd_o.capture = accept;
  assign cmd_o.exec    = (state_q == S_LOOK);

endmodule

`default_nettype wire

### hdl/bfdssm_dp.sv
`default_nettype none

module bfdssm_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire bfdssm_pkg::dp_cmd_t                   cmd_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_idx_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0]      cfg_wdata_i,
  input  wire logic [bfdssm_pkg::SessionW-1:0]       session_i,
  input  wire logic [2:0]                            event_req_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0]      fast_min_tx_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0]      required_min_rx_i,
  input  wire logic                                  fault_timer_running_i,
  input  wire logic                                  listen_timer_running_i,
  output logic [1:0]                                 status_o,
  output logic [1:0]                                 new_state_o,
  output logic                                       state_changed_o,
  output logic                                       report_change_o,
  output logic [3:0]                                 diag_code_o,
  output logic [bfdssm_pkg::IntervalW-1:0]           tx_interval_o,
  output logic                                       restart_tx_timer_o,
  output logic [1:0]                                 fault_timer_cmd_o,
  output logic                                       clear_remote_disc_o,
  output logic                                       poll_pending_o,
  output logic [bfdssm_pkg::IntervalW-1:0]           poll_min_tx_o,
  output logic                                       interval_mismatch_o
);

  localparam int unsigned IW          = bfdssm_pkg::IntervalW;
  localparam int unsigned SessIdxWLoc = bfdssm_pkg::SessIdxW;

  // configuration registers
  logic [IW-1:0] slow_tx_q;
  logic          listen_en_q;

  // session table, valid bits stand in for the reset values
  bfdssm_pkg::entry_t mem_q [bfdssm_pkg::SESSIONS];
  logic [bfdssm_pkg::SESSIONS-1:0] valid_q;

  // captured item
  logic [bfdssm_pkg::SessionW-1:0] session_q;
  bfdssm_pkg::event_e              event_q;
  logic [IW-1:0]                   fast_tx_q;
  logic [IW-1:0]                   min_rx_q;
  logic                            fault_run_q;
  logic                            listen_run_q;
  bfdssm_pkg::entry_t              rd_entry_q;
  logic                            rd_valid_q;

  // transition results
  bfdssm_pkg::entry_t     old_e, new_e;
  bfdssm_pkg::sess_st_e   nxt;
  bfdssm_pkg::status_e    stat;
  bfdssm_pkg::fault_cmd_e fcmd;
  logic                   in_range, changed, report, restart, clr, mism, listen;
  logic [SessIdxWLoc-1:0] sess_idx;

  assign sess_idx = session_q[SessIdxWLoc-1:0];
  assign in_range = {1'b0, session_q} < (bfdssm_pkg::SessionW+1)'(bfdssm_pkg::SESSIONS);
  assign old_e    = rd_valid_q ? rd_entry_q : bfdssm_pkg::EntryReset;
  assign listen   = listen_en_q && listen_run_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_tx_q   <= bfdssm_pkg::SLOW_TX_DEFAULT;
      listen_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfdssm_pkg::CfgSlowTx: slow_tx_q   <= cfg_wdata_i;
        bfdssm_pkg::CfgListen: listen_en_q <= cfg_wdata_i[0];
        default:               slow_tx_q   <= slow_tx_q;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      session_q    <= session_i;
      event_q      <= bfdssm_pkg::event_e'(event_req_i);
      fast_tx_q    <= fast_min_tx_i;
      min_rx_q     <= required_min_rx_i;
      fault_run_q  <= fault_timer_running_i;
      listen_run_q <= listen_timer_running_i;
    end
  end

  // session table read and write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_entry_q <= mem_q[session_i[SessIdxWLoc-1:0]];
    end
    if (cmd_i.exec && changed) begin
      mem_q[sess_idx] <= new_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rd_valid_q <= valid_q[session_i[SessIdxWLoc-1:0]];
      end
      if (cmd_i.exec && changed) begin
        valid_q[sess_idx] <= 1'b1;
      end
    end
  end

  // transition table
  always_comb begin
    nxt  = old_e.state;
    stat = bfdssm_pkg::STAT_OK;
    if (event_q == bfdssm_pkg::EV_INVALID) begin
      stat = bfdssm_pkg::STAT_INVALID;
    end else begin
      unique case (old_e.state)
        bfdssm_pkg::ST_ADMIN: begin
          unique case (event_q)
            bfdssm_pkg::EV_L_UP:    nxt  = bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_L_ADMIN: stat = bfdssm_pkg::STAT_LOCAL;
            default:                stat = bfdssm_pkg::STAT_SESS;
          endcase
        end
        bfdssm_pkg::ST_DOWN: begin
          unique case (event_q)
            bfdssm_pkg::EV_R_DOWN:  nxt  = bfdssm_pkg::ST_INIT;
            bfdssm_pkg::EV_R_INIT:  nxt  = bfdssm_pkg::ST_UP;
            bfdssm_pkg::EV_R_UP:    nxt  = listen ? bfdssm_pkg::ST_UP : bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_L_ADMIN: nxt  = bfdssm_pkg::ST_ADMIN;
            bfdssm_pkg::EV_L_UP:    stat = bfdssm_pkg::STAT_LOCAL;
            bfdssm_pkg::EV_TIMEOUT: stat = bfdssm_pkg::STAT_SESS;
            default:                nxt  = old_e.state;
          endcase
        end
        bfdssm_pkg::ST_INIT: begin
          unique case (event_q)
            bfdssm_pkg::EV_R_ADMIN: nxt  = bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_R_INIT:  nxt  = bfdssm_pkg::ST_UP;
            bfdssm_pkg::EV_R_UP:    nxt  = bfdssm_pkg::ST_UP;
            bfdssm_pkg::EV_L_ADMIN: nxt  = bfdssm_pkg::ST_ADMIN;
            bfdssm_pkg::EV_L_UP:    stat = bfdssm_pkg::STAT_LOCAL;
            bfdssm_pkg::EV_TIMEOUT: nxt  = bfdssm_pkg::ST_DOWN;
            default:                nxt  = old_e.state;
          endcase
        end
        default: begin
          unique case (event_q)
            bfdssm_pkg::EV_R_ADMIN: nxt  = bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_R_DOWN:  nxt  = bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_TIMEOUT: nxt  = bfdssm_pkg::ST_DOWN;
            bfdssm_pkg::EV_L_ADMIN: nxt  = bfdssm_pkg::ST_ADMIN;
            bfdssm_pkg::EV_L_UP:    stat = bfdssm_pkg::STAT_LOCAL;
            default:                nxt  = old_e.state;
          endcase
        end
      endcase
    end
  end

  assign changed = in_range && (stat == bfdssm_pkg::STAT_OK) && (nxt != old_e.state);

  // entry update on a change
  always_comb begin
    new_e   = old_e;
    restart = 1'b0;
    mism    = 1'b0;
    fcmd    = bfdssm_pkg::FT_NONE;
    clr     = 1'b0;
    report  = 1'b0;
    if (changed) begin
      new_e.state = nxt;
      // transmit interval and poll sequence
      if (nxt == bfdssm_pkg::ST_UP) begin
        mism            = (old_e.cur_tx != slow_tx_q);
        new_e.cur_tx    = fast_tx_q;
        restart         = 1'b1;
        new_e.poll_flag = 1'b1;
        new_e.poll_tx   = fast_tx_q;
        new_e.poll_rx   = min_rx_q;
      end else if (old_e.state == bfdssm_pkg::ST_UP) begin
        mism         = (old_e.cur_tx == slow_tx_q);
        new_e.cur_tx = slow_tx_q;
        restart      = 1'b1;
        if (old_e.poll_flag) begin
          new_e.poll_flag = 1'b0;
          new_e.poll_tx   = '0;
          new_e.poll_rx   = '0;
        end
      end
      // fault detection timer
      if ((nxt == bfdssm_pkg::ST_ADMIN) || (nxt == bfdssm_pkg::ST_DOWN)) begin
        fcmd = bfdssm_pkg::FT_STOP;
      end else if (!fault_run_q) begin
        fcmd = bfdssm_pkg::FT_START;
      end
      // diagnostic
      priority if (event_q == bfdssm_pkg::EV_TIMEOUT) begin
        new_e.diag = bfdssm_pkg::DIAG_EXPIRED;
      end else if ((event_q == bfdssm_pkg::EV_R_ADMIN) &&
                   (old_e.state != bfdssm_pkg::ST_DOWN)) begin
        new_e.diag = bfdssm_pkg::DIAG_NEIGHBOR;
      end else if ((event_q == bfdssm_pkg::EV_R_DOWN) &&
                   (old_e.state == bfdssm_pkg::ST_UP)) begin
        new_e.diag = bfdssm_pkg::DIAG_NEIGHBOR;
      end else if (nxt == bfdssm_pkg::ST_ADMIN) begin
        new_e.diag = bfdssm_pkg::DIAG_ADMIN;
      end else if (nxt == bfdssm_pkg::ST_UP) begin
        new_e.diag = bfdssm_pkg::DIAG_NONE;
      end else begin
        new_e.diag = old_e.diag;
      end
      clr    = (nxt == bfdssm_pkg::ST_DOWN) || (nxt == bfdssm_pkg::ST_ADMIN);
      report = (old_e.state == bfdssm_pkg::ST_UP) != (nxt == bfdssm_pkg::ST_UP);
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (in_range) begin
        status_o            <= stat;
        new_state_o         <= new_e.state;
        state_changed_o     <= changed;
        report_change_o     <= report;
        diag_code_o         <= new_e.diag;
        tx_interval_o       <= new_e.cur_tx;
        restart_tx_timer_o  <= restart;
        fault_timer_cmd_o   <= fcmd;
        clear_remote_disc_o <= clr;
        poll_pending_o      <= new_e.poll_flag;
        poll_min_tx_o       <= new_e.poll_tx;
        interval_mismatch_o <= mism;
      end else begin
        status_o            <= bfdssm_pkg::STAT_INVALID;
        new_state_o         <= '0;
        state_changed_o     <= 1'b0;
        report_change_o     <= 1'b0;
        diag_code_o         <= '0;
        tx_interval_o       <= '0;
        restart_tx_timer_o  <= 1'b0;
        fault_timer_cmd_o   <= '0;
        clear_remote_disc_o <= 1'b0;
        poll_pending_o      <= 1'b0;
        poll_min_tx_o       <= '0;
        interval_mismatch_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/bfd_session_state_machine.sv
// result path: an accepted item is captured with its session entry, then its result is
//   loaded into the result registers on the outputs, where done_o marks it
// pacing: a new item is taken only after the registered read of the session table and
//   its write-back for the last item; busy is high for the cycle between
// reset: all sessions read as admin down with the slow interval, no clearing pass needed
// results cannot be stalled by the receiver
`default_nettype none

module bfd_session_state_machine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  output logic                                  done_o,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0] cfg_wdata_i,
  input  wire logic [bfdssm_pkg::SessionW-1:0]  session_i,
  input  wire logic [2:0]                       event_req_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0] fast_min_tx_i,
  input  wire logic [bfdssm_pkg::IntervalW-1:0] required_min_rx_i,
  input  wire logic                             fault_timer_running_i,
  input  wire logic                             listen_timer_running_i,
  output logic [1:0]                            status_o,
  output logic [1:0]                            new_state_o,
  output logic                                  state_changed_o,
  output logic                                  report_change_o,
  output logic [3:0]                            diag_code_o,
  output logic [bfdssm_pkg::IntervalW-1:0]      tx_interval_o,
  output logic                                  restart_tx_timer_o,
  output logic [1:0]                            fault_timer_cmd_o,
  output logic                                  clear_remote_disc_o,
  output logic                                  poll_pending_o,
  output logic [bfdssm_pkg::IntervalW-1:0]      poll_min_tx_o,
  output logic                                  interval_mismatch_o
);

  bfdssm_pkg::dp_cmd_t cmd;

  // sequencing of each item
  bfdssm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // session table and transition logic
  bfdssm_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .session_i              (session_i),
    .event_req_i            (event_req_i),
    .fast_min_tx_i          (fast_min_tx_i),
    .required_min_rx_i      (required_min_rx_i),
    .fault_timer_running_i  (fault_timer_running_i),
    .listen_timer_running_i (listen_timer_running_i),
    .status_o               (status_o),
    .new_state_o            (new_state_o),
    .state_changed_o        (state_changed_o),
    .report_change_o        (report_change_o),
    .diag_code_o            (diag_code_o),
    .tx_interval_o          (tx_interval_o),
    .restart_tx_timer_o     (restart_tx_timer_o),
    .fault_timer_cmd_o      (fault_timer_cmd_o),
    .clear_remote_disc_o    (clear_remote_disc_o),
    .poll_pending_o         (poll_pending_o),
    .poll_min_tx_o          (poll_min_tx_o),
    .interval_mismatch_o    (interval_mismatch_o)
  );

endmodule

`default_nettype wire

### sim/tb_bfd_session_state_machine.sv
`timescale 1ns / 100ps

module tb_bfd_session_state_machine;
  import bfdssm_pkg::*;

  localparam int unsigned WdogLimit    = 1000;
  localparam int unsigned SettleCycles = 4;

  // one expected outcome of a session event
  typedef struct packed {
    status_e              status;
    sess_st_e             new_state;
    logic                 changed;
    logic                 report;
    logic [3:0]           diag;
    logic [IntervalW-1:0] tx;
    logic                 restart;
    fault_cmd_e           fcmd;
    logic                 clr;
    logic                 poll;
    logic [IntervalW-1:0] poll_tx;
    logic                 mism;
  } bfd_outcome_t;

  // one row of the directed event list
  typedef struct {
    logic [SessionW-1:0]  sess;
    event_e               ev;
    logic [IntervalW-1:0] fast;
    logic [IntervalW-1:0] rx;
    logic                 fault_run;
    logic                 listen_run;
    logic                 pinned;
    status_e              pin_status;
    sess_st_e             pin_state;
  } event_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 done_o;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [IntervalW-1:0] cfg_wdata_i;
  logic [SessionW-1:0]  session_i;
  logic [2:0]           event_req_i;
  logic [IntervalW-1:0] fast_min_tx_i;
  logic [IntervalW-1:0] required_min_rx_i;
  logic                 fault_timer_running_i;
  logic                 listen_timer_running_i;
  logic [1:0]           status_o;
  logic [1:0]           new_state_o;
  logic                 state_changed_o;
  logic                 report_change_o;
  logic [3:0]           diag_code_o;
  logic [IntervalW-1:0] tx_interval_o;
  logic                 restart_tx_timer_o;
  logic [1:0]           fault_timer_cmd_o;
  logic                 clear_remote_disc_o;
  logic                 poll_pending_o;
  logic [IntervalW-1:0] poll_min_tx_o;
  logic                 interval_mismatch_o;

  // typed-in status and state that ride along with a directed item
  logic                 pin_en;
  status_e              pin_status;
  sess_st_e             pin_state;

  // mirror of the session table and the registers
  sess_st_e             st_tbl   [SESSIONS];
  logic [3:0]           diag_tbl [SESSIONS];
  logic [IntervalW-1:0] tx_tbl   [SESSIONS];
  logic                 poll_tbl [SESSIONS];
  logic [IntervalW-1:0] ptx_tbl  [SESSIONS];
  logic [IntervalW-1:0] slow_cfg;
  logic                 listen_cfg;

  bfd_outcome_t         pending_q[$];
  bfd_outcome_t         want;
  event_row_t           dir_rows[$];
  int unsigned          fails;
  int unsigned          stall_cycles;

  bfd_session_state_machine u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start                  (start),
    .busy                   (busy),
    .done_o                 (done_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .session_i              (session_i),
    .event_req_i            (event_req_i),
    .fast_min_tx_i          (fast_min_tx_i),
    .required_min_rx_i      (required_min_rx_i),
    .fault_timer_running_i  (fault_timer_running_i),
    .listen_timer_running_i (listen_timer_running_i),
    .status_o               (status_o),
    .new_state_o            (new_state_o),
    .state_changed_o        (state_changed_o),
    .report_change_o        (report_change_o),
    .diag_code_o            (diag_code_o),
    .tx_interval_o          (tx_interval_o),
    .restart_tx_timer_o     (restart_tx_timer_o),
    .fault_timer_cmd_o      (fault_timer_cmd_o),
    .clear_remote_disc_o    (clear_remote_disc_o),
    .poll_pending_o         (poll_pending_o),
    .poll_min_tx_o          (poll_min_tx_o),
    .interval_mismatch_o    (interval_mismatch_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // apply one event to the mirrored session table and work out its outcome
  function automatic bfd_outcome_t session_outcome(logic [SessionW-1:0] s, event_e ev,
                                                   logic [IntervalW-1:0] fast,
                                                   logic fault_run, logic listen_run);
    sess_st_e     old;
    sess_st_e     nxt;
    status_e      stat;
    logic         listen;
    logic [3:0]   dg;
    bfd_outcome_t r;
    r = '0;
    if (s >= SESSIONS) begin
      r.status = STAT_INVALID;
      return r;
    end
    old    = st_tbl[s];
    nxt    = old;
    stat   = STAT_OK;
    listen = listen_cfg && listen_run;
    // transition table
    if (ev == EV_INVALID) begin
      stat = STAT_INVALID;
    end else begin
      case (old)
        ST_ADMIN: begin
          if (ev == EV_L_UP) nxt = ST_DOWN;
          else if (ev == EV_L_ADMIN) stat = STAT_LOCAL;
          else stat = STAT_SESS;
        end
        ST_DOWN: begin
          case (ev)
            EV_R_DOWN:  nxt = ST_INIT;
            EV_R_INIT:  nxt = ST_UP;
            EV_R_UP:    if (listen) nxt = ST_UP;
            EV_L_ADMIN: nxt = ST_ADMIN;
            EV_L_UP:    stat = STAT_LOCAL;
            EV_TIMEOUT: stat = STAT_SESS;
            default: ;
          endcase
        end
        ST_INIT: begin
          case (ev)
            EV_R_ADMIN, EV_TIMEOUT: nxt = ST_DOWN;
            EV_R_INIT, EV_R_UP:     nxt = ST_UP;
            EV_L_ADMIN:             nxt = ST_ADMIN;
            EV_L_UP:                stat = STAT_LOCAL;
            default: ;
          endcase
        end
        default: begin
          case (ev)
            EV_R_ADMIN, EV_R_DOWN, EV_TIMEOUT: nxt = ST_DOWN;
            EV_L_ADMIN:                        nxt = ST_ADMIN;
            EV_L_UP:                           stat = STAT_LOCAL;
            default: ;
          endcase
        end
      endcase
    end
    r.status    = stat;
    r.new_state = old;
    if (stat == STAT_OK && nxt != old) begin
      r.changed   = 1'b1;
      r.new_state = nxt;
      // interval switch and poll sequence
      if (nxt == ST_UP) begin
        r.mism     = tx_tbl[s] != slow_cfg;
        tx_tbl[s]  = fast;
        r.restart  = 1'b1;
        poll_tbl[s] = 1'b1;
        ptx_tbl[s] = fast;
      end else if (old == ST_UP) begin
        r.mism     = tx_tbl[s] == slow_cfg;
        tx_tbl[s]  = slow_cfg;
        r.restart  = 1'b1;
        poll_tbl[s] = 1'b0;
        ptx_tbl[s] = '0;
      end
      // fault timer
      if (nxt == ST_ADMIN || nxt == ST_DOWN) r.fcmd = FT_STOP;
      else if (!fault_run) r.fcmd = FT_START;
      // diagnostic
      dg = diag_tbl[s];
      if (ev == EV_TIMEOUT) dg = DIAG_EXPIRED;
      else if (ev == EV_R_ADMIN && old != ST_DOWN) dg = DIAG_NEIGHBOR;
      else if (ev == EV_R_DOWN && old == ST_UP) dg = DIAG_NEIGHBOR;
      else if (nxt == ST_ADMIN) dg = DIAG_ADMIN;
      else if (nxt == ST_UP) dg = DIAG_NONE;
      diag_tbl[s] = dg;
      r.clr       = (nxt == ST_DOWN || nxt == ST_ADMIN);
      r.report    = (old == ST_UP) != (nxt == ST_UP);
      st_tbl[s]   = nxt;
    end
    r.diag    = diag_tbl[s];
    r.tx      = tx_tbl[s];
    r.poll    = poll_tbl[s];
    r.poll_tx = ptx_tbl[s];
    return r;
  endfunction

  task automatic check_field(string name, logic [IntervalW-1:0] exp_v,
                             logic [IntervalW-1:0] act_v);
    if (act_v !== exp_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // mirror model, result checking and watchdog
  always @(posedge clk_i) begin : monitor
    int k;
    if (!rst_ni) begin
      for (k = 0; k < SESSIONS; k++) begin
        st_tbl[k]   = ST_ADMIN;
        diag_tbl[k] = DIAG_NONE;
        tx_tbl[k]   = SLOW_TX_DEFAULT;
        poll_tbl[k] = 1'b0;
        ptx_tbl[k]  = '0;
      end
      slow_cfg     = SLOW_TX_DEFAULT;
      listen_cfg   = 1'b0;
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      // result against the oldest outstanding expectation
      if (done_o) begin
        stall_cycles = 0;
        if (pending_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                   $time, status_o);
        end else begin
          want = pending_q.pop_front();
          check_field("status", IntervalW'(want.status), IntervalW'(status_o));
          check_field("new_state", IntervalW'(want.new_state), IntervalW'(new_state_o));
          check_field("state_changed", IntervalW'(want.changed), IntervalW'(state_changed_o));
          check_field("report_change", IntervalW'(want.report), IntervalW'(report_change_o));
          check_field("diag_code", IntervalW'(want.diag), IntervalW'(diag_code_o));
          check_field("tx_interval", want.tx, tx_interval_o);
          check_field("restart_tx_timer", IntervalW'(want.restart),
                      IntervalW'(restart_tx_timer_o));
          check_field("fault_timer_cmd", IntervalW'(want.fcmd), IntervalW'(fault_timer_cmd_o));
          check_field("clear_remote_disc", IntervalW'(want.clr),
                      IntervalW'(clear_remote_disc_o));
          check_field("poll_pending", IntervalW'(want.poll), IntervalW'(poll_pending_o));
          check_field("poll_min_tx", want.poll_tx, poll_min_tx_o);
          check_field("interval_mismatch", IntervalW'(want.mism),
                      IntervalW'(interval_mismatch_o));
        end
      end
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSlowTx) slow_cfg = cfg_wdata_i;
        else listen_cfg = cfg_wdata_i[0];
      end
      // accepted item
      if (start && !busy) begin
        stall_cycles = 0;
        want = session_outcome(session_i, event_e'(event_req_i), fast_min_tx_i,
                               fault_timer_running_i, listen_timer_running_i);
        if (pin_en) begin
          want.status    = pin_status;
          want.new_state = pin_state;
        end
        pending_q.push_back(want);
      end
      if (stall_cycles >= WdogLimit) begin
        $display("** bfd_session_state_machine: FAILED **");
        $finish;
      end
    end
  end

  // all driving tasks start and end at a falling edge

  task automatic send_event(logic [SessionW-1:0] s, event_e ev, logic [IntervalW-1:0] fast,
                            logic [IntervalW-1:0] rx, logic fault_run, logic listen_run,
                            logic pinned, status_e ps, sess_st_e pst);
    session_i              <= s;
    event_req_i            <= ev;
    fast_min_tx_i          <= fast;
    required_min_rx_i      <= rx;
    fault_timer_running_i  <= fault_run;
    listen_timer_running_i <= listen_run;
    pin_en                 <= pinned;
    pin_status             <= ps;
    pin_state              <= pst;
    start                  <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // wait for every outstanding result, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [IntervalW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_row(logic [SessionW-1:0] s, event_e ev, logic [IntervalW-1:0] fast,
                         logic [IntervalW-1:0] rx, logic fault_run, logic listen_run,
                         logic pinned, status_e ps, sess_st_e pst);
    event_row_t row;
    row.sess       = s;
    row.ev         = ev;
    row.fast       = fast;
    row.rx         = rx;
    row.fault_run  = fault_run;
    row.listen_run = listen_run;
    row.pinned     = pinned;
    row.pin_status = ps;
    row.pin_state  = pst;
    dir_rows.push_back(row);
  endtask

  // mostly events that move the session on, the rest anything at all
  function automatic event_e pick_event(sess_st_e st);
    event_e ev;
    if ($urandom_range(0, 3) == 0) begin
      ev = event_e'($urandom_range(0, 7));
    end else begin
      case (st)
        ST_ADMIN: ev = EV_L_UP;
        ST_DOWN: begin
          case ($urandom_range(0, 3))
            0: ev = EV_R_DOWN;
            1: ev = EV_R_INIT;
            2: ev = EV_R_UP;
            default: ev = EV_L_ADMIN;
          endcase
        end
        ST_INIT: begin
          case ($urandom_range(0, 4))
            0: ev = EV_R_ADMIN;
            1: ev = EV_R_INIT;
            2: ev = EV_R_UP;
            3: ev = EV_TIMEOUT;
            default: ev = EV_L_ADMIN;
          endcase
        end
        default: begin
          case ($urandom_range(0, 4))
            0: ev = EV_R_ADMIN;
            1: ev = EV_R_DOWN;
            2: ev = EV_TIMEOUT;
            3: ev = EV_L_ADMIN;
            default: ev = EV_R_UP;
          endcase
        end
      endcase
    end
    return ev;
  endfunction

  // extremes and the slow value turn up often so both mismatch senses occur
  function automatic logic [IntervalW-1:0] pick_interval();
    logic [IntervalW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = slow_cfg;
      3: v = $urandom_range(1, 100);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // random events in bursts, with or without gaps between bursts
  task automatic run_random(int unsigned n, int unsigned sess_hi, bit gappy);
    int unsigned         burst;
    int unsigned         i;
    logic [SessionW-1:0] s;
    burst = 0;
    for (i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (gappy) hold_off($urandom_range(0, 5));
      end
      s = SessionW'($urandom_range(0, sess_hi));
      send_event(s, pick_event(st_tbl[s]), pick_interval(), pick_interval(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                 STAT_OK, ST_ADMIN);
      burst--;
    end
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned i;
    rst_ni                 <= 1'b0;
    start                  <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CfgSlowTx;
    cfg_wdata_i            <= '0;
    session_i              <= '0;
    event_req_i            <= EV_R_ADMIN;
    fast_min_tx_i          <= '0;
    required_min_rx_i      <= '0;
    fault_timer_running_i  <= 1'b0;
    listen_timer_running_i <= 1'b0;
    pin_en                 <= 1'b0;
    pin_status             <= STAT_OK;
    pin_state              <= ST_ADMIN;
    fails                   = 0;

    // errors out of reset, then a walk through every state with a selection of events
    add_row(6'd0,  EV_L_ADMIN, '0, '0, 1'b0, 1'b0, 1'b1, STAT_LOCAL,   ST_ADMIN);
    add_row(6'd0,  EV_R_UP,    '0, '0, 1'b0, 1'b1, 1'b1, STAT_SESS,    ST_ADMIN);
    add_row(6'd0,  EV_INVALID, '1, '1, 1'b1, 1'b1, 1'b1, STAT_INVALID, ST_ADMIN);
    add_row(6'd63, EV_R_ADMIN, '1, '0, 1'b1, 1'b0, 1'b1, STAT_SESS,    ST_ADMIN);
    add_row(6'd0,  EV_L_UP,    '1, '1, 1'b0, 1'b0, 1'b1, STAT_OK,      ST_DOWN);
    add_row(6'd0,  EV_L_UP,    '0, '0, 1'b1, 1'b1, 1'b1, STAT_LOCAL,   ST_DOWN);
    add_row(6'd0,  EV_TIMEOUT, '0, '0, 1'b1, 1'b0, 1'b1, STAT_SESS,    ST_DOWN);
    // listen shortcut off: remote up in down stays down
    add_row(6'd0,  EV_R_UP,    '1, '1, 1'b0, 1'b1, 1'b1, STAT_OK,      ST_DOWN);
    add_row(6'd0,  EV_R_ADMIN, '1, '0, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd0,  EV_R_DOWN,  '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd0,  EV_INVALID, '0, '0, 1'b0, 1'b0, 1'b1, STAT_INVALID, ST_INIT);
    add_row(6'd0,  EV_L_UP,    '0, '0, 1'b0, 1'b0, 1'b1, STAT_LOCAL,   ST_INIT);
    add_row(6'd0,  EV_R_INIT,  '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd0,  EV_R_UP,    '0, '0, 1'b1, 1'b1, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd0,  EV_INVALID, '1, '1, 1'b1, 1'b1, 1'b1, STAT_INVALID, ST_UP);
    add_row(6'd0,  EV_R_DOWN,  '0, '0, 1'b1, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_L_UP,    '0, '0, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_R_DOWN,  '0, '1, 1'b1, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_TIMEOUT, '0, '0, 1'b1, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_R_INIT,  '0, '0, 1'b1, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_L_ADMIN, '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_L_UP,    '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_R_DOWN,  '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd63, EV_R_ADMIN, '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);
    add_row(6'd0,  EV_L_ADMIN, '1, '1, 1'b0, 1'b0, 1'b0, STAT_OK,      ST_ADMIN);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < dir_rows.size(); i++)
      send_event(dir_rows[i].sess, dir_rows[i].ev, dir_rows[i].fast, dir_rows[i].rx,
                 dir_rows[i].fault_run, dir_rows[i].listen_run, dir_rows[i].pinned,
                 dir_rows[i].pin_status, dir_rows[i].pin_state);

    // slow interval of one, listen shortcut on, few sessions
    drain();
    write_reg(CfgListen, ($urandom & 32'hFFFF_FFFE) | 32'd1);
    write_reg(CfgSlowTx, 32'd1);
    run_random(300, 3, 1'b1);

    // highest slow interval, shortcut off, whole table, back to back
    drain();
    write_reg(CfgSlowTx, '1);
    write_reg(CfgListen, $urandom & 32'hFFFF_FFFE);
    run_random(300, SESSIONS - 1, 1'b0);

    // random slow interval rewritten under live sessions
    drain();
    write_reg(CfgSlowTx, $urandom);
    write_reg(CfgListen, 32'd1);
    run_random(400, 7, 1'b1);

    // back to the default interval, shortcut off
    drain();
    write_reg(CfgSlowTx, SLOW_TX_DEFAULT);
    write_reg(CfgListen, '0);
    run_random(300, SESSIONS - 1, 1'b1);

    // two sessions hammered with the shortcut on
    drain();
    write_reg(CfgListen, 32'd1);
    run_random(300, 1, 1'b0);

    drain();
    if (fails == 0 && pending_q.size() == 0) begin
      $display("** bfd_session_state_machine: PASSED **");
    end else begin
      $display("** bfd_session_state_machine: FAILED **");
    end
    $finish;
  end

endmodule
